// ===== src/assert_macros.svh =====
// Shared assertion macros for the tokenizer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dft_pkg.sv =====
`default_nettype none

package dft_pkg;

    localparam int POS_WIDTH         = 32;
    localparam int CONTENT_LEN_WIDTH = 16;
    localparam int CFG_IDX_WIDTH     = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIELD_SEP    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RECORD_SEP   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ESCAPE       = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUOTE_TOGGLE = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUOTE_OPEN   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_QUOTE_CLOSE  = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_CLASS_ENABLE = 3'd6;

    // byte classes, in priority order
    localparam logic [2:0] CL_FIELD  = 3'd0;
    localparam logic [2:0] CL_RECORD = 3'd1;
    localparam logic [2:0] CL_ESCAPE = 3'd2;
    localparam logic [2:0] CL_TOGGLE = 3'd3;
    localparam logic [2:0] CL_OPEN   = 3'd4;
    localparam logic [2:0] CL_CLOSE  = 3'd5;
    localparam logic [2:0] CL_NONE   = 3'd6;

    // class of the previous byte
    localparam logic [1:0] PC_ANY    = 2'd0;
    localparam logic [1:0] PC_FIELD  = 2'd1;
    localparam logic [1:0] PC_RECORD = 2'd2;
    localparam logic [1:0] PC_ESCAPE = 2'd3;

    typedef struct packed {
        logic [7:0] field_sep;
        logic [7:0] record_sep;
        logic [7:0] escape;
        logic [7:0] quote_toggle;
        logic [7:0] quote_open;
        logic [7:0] quote_close;
        logic [5:0] class_enable;
    } t_cfg;

    typedef struct packed {
        logic                         content_valid;
        logic [7:0]                   content_byte;
        logic                         field_end;
        logic                         record_end;
        logic [POS_WIDTH-1:0]         field_position;
        logic [POS_WIDTH-1:0]         field_raw_length;
        logic [CONTENT_LEN_WIDTH-1:0] field_content_length;
    } t_result;

endpackage

`default_nettype wire

// ===== src/dft_in_if.sv =====
`default_nettype none

interface dft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/dft_out_if.sv =====
`default_nettype none

interface dft_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  content_valid;
    logic [7:0]                            content_byte;
    logic                                  field_end;
    logic                                  record_end;
    logic [dft_pkg::POS_WIDTH-1:0]         field_position;
    logic [dft_pkg::POS_WIDTH-1:0]         field_raw_length;
    logic [dft_pkg::CONTENT_LEN_WIDTH-1:0] field_content_length;

    modport source (
        output valid, output content_valid, output content_byte, output field_end,
        output record_end, output field_position, output field_raw_length,
        output field_content_length, input ready
    );
    modport sink (
        input valid, input content_valid, input content_byte, input field_end,
        input record_end, input field_position, input field_raw_length,
        input field_content_length, output ready
    );
endinterface

`default_nettype wire

// ===== src/delimited_field_tokenizer_unit.sv =====
// Channel | Dir | Payload                                           | Handshake
// i_in    | in  | data_byte[7:0]                                    | valid/ready
// o_out   | out | content_valid/byte, field_end, record_end,        | valid/ready
//         |     | field_position, field_raw_length, kept byte count |
// i_cfg_* | in  | index[2:0], data[7:0]                             | i_cfg_we
//
// One byte per cycle while the output is not stalled: a beat is held in the input
// register, and its result is then captured in the output register.
// The combinational path is the classify compares plus the 32-bit offset subtract.
// Reset is synchronous, active low; it loads the register defaults and clears state.
// A stalled output holds its result; the input keeps taking beats until both
// registers are full.
`default_nettype none

module delimited_field_tokenizer_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    dft_in_if.sink                            i_in,
    dft_out_if.source                         o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [dft_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  wire logic [7:0]                   i_cfg_data
);
    import dft_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    result;
    logic       out_adv;
    logic       step;
    logic       in_take;

    assign out_adv   = !r_out_valid || o_out.ready;
    assign step      = r_in_valid && out_adv;
    assign i_in.ready = !r_in_valid || out_adv;
    assign in_take   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.field_sep    <= 8'd44;
            r_cfg.record_sep   <= 8'd10;
            r_cfg.escape       <= 8'd92;
            r_cfg.quote_toggle <= 8'd34;
            r_cfg.quote_open   <= 8'd0;
            r_cfg.quote_close  <= 8'd0;
            r_cfg.class_enable <= 6'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIELD_SEP:    r_cfg.field_sep    <= i_cfg_data;
                CFG_RECORD_SEP:   r_cfg.record_sep   <= i_cfg_data;
                CFG_ESCAPE:       r_cfg.escape       <= i_cfg_data;
                CFG_QUOTE_TOGGLE: r_cfg.quote_toggle <= i_cfg_data;
                CFG_QUOTE_OPEN:   r_cfg.quote_open   <= i_cfg_data;
                CFG_QUOTE_CLOSE:  r_cfg.quote_close  <= i_cfg_data;
                CFG_CLASS_ENABLE: r_cfg.class_enable <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    dft_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid                = r_out_valid;
    assign o_out.content_valid        = r_out.content_valid;
    assign o_out.content_byte         = r_out.content_byte;
    assign o_out.field_end            = r_out.field_end;
    assign o_out.record_end           = r_out.record_end;
    assign o_out.field_position       = r_out.field_position;
    assign o_out.field_raw_length     = r_out.field_raw_length;
    assign o_out.field_content_length = r_out.field_content_length;

endmodule

`default_nettype wire

// ===== src/dft_classify.sv =====
`default_nettype none

module dft_classify (
    input  wire dft_pkg::t_cfg i_cfg,
    input  wire logic [7:0]    i_byte,
    output logic [2:0]         o_cls
);
    import dft_pkg::*;

    // first enabled match wins
    always_comb begin
        if (i_cfg.class_enable[0] && i_byte == i_cfg.field_sep) begin
            o_cls = CL_FIELD;
        end else if (i_cfg.class_enable[1] && i_byte == i_cfg.record_sep) begin
            o_cls = CL_RECORD;
        end else if (i_cfg.class_enable[2] && i_byte == i_cfg.escape) begin
            o_cls = CL_ESCAPE;
        end else if (i_cfg.class_enable[3] && i_byte == i_cfg.quote_toggle) begin
            o_cls = CL_TOGGLE;
        end else if (i_cfg.class_enable[4] && i_byte == i_cfg.quote_open) begin
            o_cls = CL_OPEN;
        end else if (i_cfg.class_enable[5] && i_byte == i_cfg.quote_close) begin
            o_cls = CL_CLOSE;
        end else begin
            o_cls = CL_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== src/dft_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module dft_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire dft_pkg::t_cfg    i_cfg,
    output dft_pkg::t_result      o_result
);
    import dft_pkg::*;

    localparam logic [CONTENT_LEN_WIDTH-1:0] CNT_MAX = '1;

    logic [1:0]                   r_prev,   n_prev;
    logic                         r_in_str, n_in_str;
    logic [POS_WIDTH-1:0]         r_offset, n_offset;
    logic [POS_WIDTH-1:0]         r_fstart, n_fstart;
    logic [CONTENT_LEN_WIDTH-1:0] r_count,  n_count;

    logic [2:0] cls;
    logic       after_esc;
    logic       taken;
    logic       fend;

    dft_classify u_classify (
        .i_cfg  (i_cfg),
        .i_byte (i_byte),
        .o_cls  (cls)
    );

    always_comb begin
        after_esc = (r_prev == PC_ESCAPE);
        n_fstart  = (r_prev == PC_FIELD || r_prev == PC_RECORD) ? r_offset : r_fstart;
        n_offset  = r_offset + POS_WIDTH'(1);
        n_prev    = r_prev;
        n_in_str  = r_in_str;
        n_count   = r_count;
        taken     = 1'b0;
        fend      = 1'b0;

        case (cls)
            CL_FIELD, CL_RECORD: begin
                if (!r_in_str && !after_esc) begin
                    taken   = 1'b1;
                    fend    = 1'b1;
                    n_count = '0;
                    n_prev  = (cls == CL_RECORD) ? PC_RECORD : PC_FIELD;
                end
            end
            CL_ESCAPE: begin
                if (!r_in_str && !after_esc) begin
                    taken  = 1'b1;
                    n_prev = PC_ESCAPE;
                end
            end
            CL_TOGGLE: begin
                if (!after_esc) begin
                    taken    = 1'b1;
                    n_in_str = !r_in_str;
                end
            end
            CL_OPEN: begin
                if (!r_in_str && !after_esc) begin
                    taken    = 1'b1;
                    n_in_str = 1'b1;
                end
            end
            CL_CLOSE: begin
                if (r_in_str && !after_esc) begin
                    taken    = 1'b1;
                    n_in_str = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // kept content byte: count it, saturating
        if (!taken) begin
            n_prev = PC_ANY;
            if (r_count != CNT_MAX) begin
                n_count = r_count + CONTENT_LEN_WIDTH'(1);
            end
        end

        o_result.content_valid        = !taken;
        o_result.content_byte         = taken ? 8'd0 : i_byte;
        o_result.field_end            = fend;
        o_result.record_end           = fend && (cls == CL_RECORD);
        o_result.field_position       = fend ? n_fstart : '0;
        o_result.field_raw_length     = fend ? (n_offset - n_fstart) : '0;
        o_result.field_content_length = fend ? r_count : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= PC_ANY;
            r_in_str <= 1'b0;
            r_offset <= '0;
            r_fstart <= '0;
            r_count  <= '0;
        end else if (i_step) begin
            r_prev   <= n_prev;
            r_in_str <= n_in_str;
            r_offset <= n_offset;
            r_fstart <= n_fstart;
            r_count  <= n_count;
        end
    end

    `ASSERT_CLK(a_offset_adv, i_clk, i_rst_n, i_step |=> r_offset == $past(r_offset) + POS_WIDTH'(1), "offset did not advance on a beat")
    `ASSERT_CLK(a_state_hold, i_clk, i_rst_n, !i_step |=> $stable(r_offset) && $stable(r_in_str) && $stable(r_count), "state moved without a beat")
    `ASSERT_CLK(a_field_clear, i_clk, i_rst_n, i_step && o_result.field_end |=> r_count == '0 && r_prev != PC_ANY, "field end did not clear the content count")
    `ASSERT_CLK(a_kept_any, i_clk, i_rst_n, i_step && o_result.content_valid |=> r_prev == PC_ANY, "kept byte left a special previous class")

endmodule

`default_nettype wire
